>>> sv/cau_pkg.sv
// Shared definitions for the complex arithmetic unit: operation and status codes,
// and the control group that travels alongside each request. No dependencies.
`default_nettype none

package cau_pkg;

	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_SUB = 2'd1;
	localparam logic [1:0] MODE_MUL = 2'd2;
	localparam logic [1:0] MODE_DIV = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [1:0] st;
		logic       neg_re;
		logic       neg_im;
		logic       big_re;
		logic       big_im;
		logic       zero;
	} ctl_t;

endpackage

`default_nettype wire

>>> sv/cau_front.sv
// Front end of the complex arithmetic unit: input register, products, sums,
// magnitudes and the quotient range check. Depends on cau_pkg.
`default_nettype none

module cau_front import cau_pkg::*; #(
	parameter int W  = 32,
	parameter int F  = 16,
	parameter int RW = 3 * W + F + 2
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_stall,
	input  wire logic [1:0]          mode,
	input  wire logic signed [W-1:0] a_re,
	input  wire logic signed [W-1:0] a_im,
	input  wire logic signed [W-1:0] b_re,
	input  wire logic signed [W-1:0] b_im,
	output      logic                vld_o,
	input  wire logic                rdy_i,
	output      ctl_t                ctl_o,
	output      logic [W-1:0]        res_re_o,
	output      logic [W-1:0]        res_im_o,
	output      logic [2*W-1:0]      den_o,
	output      logic [RW-1:0]       num_re_o,
	output      logic [RW-1:0]       num_im_o
);

	localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5     = !v_s5 || rdy_i;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// Stage 1: operands registered as they arrive.
	logic [1:0]          mode_s1;
	logic signed [W-1:0] ar_s1, ai_s1, br_s1, bi_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			mode_s1 <= mode;
			ar_s1   <= a_re;
			ai_s1   <= a_im;
			br_s1   <= b_re;
			bi_s1   <= b_im;
		end
	end

	// Stage 2: the six full-width products, and add or subtract with saturation.
	logic signed [W:0]     sum_re, sum_im;
	logic signed [2*W-1:0] p_rr, p_ii, p_ri, p_ir, sq_r, sq_i;

	always_comb begin
		if (mode_s1 == MODE_SUB) begin
			sum_re = $signed({ar_s1[W-1], ar_s1}) - $signed({br_s1[W-1], br_s1});
			sum_im = $signed({ai_s1[W-1], ai_s1}) - $signed({bi_s1[W-1], bi_s1});
		end else begin
			sum_re = $signed({ar_s1[W-1], ar_s1}) + $signed({br_s1[W-1], br_s1});
			sum_im = $signed({ai_s1[W-1], ai_s1}) + $signed({bi_s1[W-1], bi_s1});
		end
		p_rr = ar_s1 * br_s1;
		p_ii = ai_s1 * bi_s1;
		p_ri = ar_s1 * bi_s1;
		p_ir = ai_s1 * br_s1;
		sq_r = br_s1 * br_s1;
		sq_i = bi_s1 * bi_s1;
	end

	logic [1:0]            mode_s2;
	logic signed [2*W-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2, sq_r_s2, sq_i_s2;
	logic [W-1:0]          as_re_s2, as_im_s2;
	logic                  as_ovf_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			mode_s2   <= mode_s1;
			p_rr_s2   <= p_rr;
			p_ii_s2   <= p_ii;
			p_ri_s2   <= p_ri;
			p_ir_s2   <= p_ir;
			sq_r_s2   <= sq_r;
			sq_i_s2   <= sq_i;
			as_re_s2  <= (sum_re[W] != sum_re[W-1]) ? (sum_re[W] ? SMIN : SMAX) : sum_re[W-1:0];
			as_im_s2  <= (sum_im[W] != sum_im[W-1]) ? (sum_im[W] ? SMIN : SMAX) : sum_im[W-1:0];
			as_ovf_s2 <= (sum_re[W] != sum_re[W-1]) || (sum_im[W] != sum_im[W-1]);
		end
	end

	// Stage 3: combine products. Divide uses a times the conjugate of b.
	logic signed [2*W:0] xrr, xii, xri, xir;

	assign xrr = $signed({p_rr_s2[2*W-1], p_rr_s2});
	assign xii = $signed({p_ii_s2[2*W-1], p_ii_s2});
	assign xri = $signed({p_ri_s2[2*W-1], p_ri_s2});
	assign xir = $signed({p_ir_s2[2*W-1], p_ir_s2});

	logic [1:0]          mode_s3;
	logic signed [2*W:0] v_re_s3, v_im_s3;
	logic [2*W-1:0]      den_s3;
	logic [W-1:0]        as_re_s3, as_im_s3;
	logic                as_ovf_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			mode_s3   <= mode_s2;
			v_re_s3   <= (mode_s2 == MODE_MUL) ? xrr - xii : xrr + xii;
			v_im_s3   <= (mode_s2 == MODE_MUL) ? xri + xir : xir - xri;
			den_s3    <= $unsigned(sq_r_s2) + $unsigned(sq_i_s2);
			as_re_s3  <= as_re_s2;
			as_im_s3  <= as_im_s2;
			as_ovf_s3 <= as_ovf_s2;
		end
	end

	// Stage 4: floor shift and saturation for multiply, magnitudes for divide.
	logic signed [2*W:0] sh_re, sh_im;
	logic                mo_re, mo_im;
	logic [W-1:0]        ms_re, ms_im;
	ctl_t                ctl_n4;
	logic [W-1:0]        res_re_n4, res_im_n4;

	always_comb begin
		sh_re = v_re_s3 >>> F;
		sh_im = v_im_s3 >>> F;
		mo_re = !((&sh_re[2*W:W-1]) || !(|sh_re[2*W:W-1]));
		mo_im = !((&sh_im[2*W:W-1]) || !(|sh_im[2*W:W-1]));
		ms_re = mo_re ? (sh_re[2*W] ? SMIN : SMAX) : sh_re[W-1:0];
		ms_im = mo_im ? (sh_im[2*W] ? SMIN : SMAX) : sh_im[W-1:0];
		ctl_n4        = '0;
		ctl_n4.mode   = mode_s3;
		ctl_n4.neg_re = v_re_s3[2*W];
		ctl_n4.neg_im = v_im_s3[2*W];
		ctl_n4.zero   = (den_s3 == '0);
		unique case (mode_s3)
			MODE_ADD, MODE_SUB: begin
				res_re_n4 = as_re_s3;
				res_im_n4 = as_im_s3;
				ctl_n4.st = as_ovf_s3 ? ST_OVF : ST_OK;
			end
			MODE_MUL: begin
				res_re_n4 = ms_re;
				res_im_n4 = ms_im;
				ctl_n4.st = (mo_re || mo_im) ? ST_OVF : ST_OK;
			end
			default: begin
				res_re_n4 = '0;
				res_im_n4 = '0;
				ctl_n4.st = ST_OK;
			end
		endcase
	end

	ctl_t         ctl_s4;
	logic [W-1:0] res_re_s4, res_im_s4;
	logic [2*W:0] mag_re_s4, mag_im_s4;
	logic [2*W-1:0] den_s4;

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			ctl_s4    <= ctl_n4;
			res_re_s4 <= res_re_n4;
			res_im_s4 <= res_im_n4;
			mag_re_s4 <= v_re_s3[2*W] ? $unsigned(-v_re_s3) : $unsigned(v_re_s3);
			mag_im_s4 <= v_im_s3[2*W] ? $unsigned(-v_im_s3) : $unsigned(v_im_s3);
			den_s4    <= den_s3;
		end
	end

	// Stage 5: scale the dividend and flag quotients that cannot fit the result.
	logic [RW-1:0] num_re, num_im, den_top;
	ctl_t          ctl_n5;

	always_comb begin
		num_re  = {{(RW-2*W-1){1'b0}}, mag_re_s4} << F;
		num_im  = {{(RW-2*W-1){1'b0}}, mag_im_s4} << F;
		den_top = {{(RW-2*W){1'b0}}, den_s4} << (W + 1);
		ctl_n5        = ctl_s4;
		ctl_n5.big_re = (num_re >= den_top);
		ctl_n5.big_im = (num_im >= den_top);
	end

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			ctl_o    <= ctl_n5;
			res_re_o <= res_re_s4;
			res_im_o <= res_im_s4;
			den_o    <= den_s4;
			num_re_o <= num_re;
			num_im_o <= num_im;
		end
	end

	assign vld_o = v_s5;

endmodule

`default_nettype wire

>>> sv/cau_div_step.sv
// One restoring division stage: decides one quotient bit for both parts.
// Depends on cau_pkg.
`default_nettype none

module cau_div_step import cau_pkg::*; #(
	parameter int W   = 32,
	parameter int RW  = 3 * W + 18,
	parameter int BIT = 0
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           vld_i,
	output      logic           rdy_o,
	input  wire ctl_t           ctl_i,
	input  wire logic [W-1:0]   res_re_i,
	input  wire logic [W-1:0]   res_im_i,
	input  wire logic [2*W-1:0] den_i,
	input  wire logic [RW-1:0]  rem_re_i,
	input  wire logic [RW-1:0]  rem_im_i,
	input  wire logic [W:0]     q_re_i,
	input  wire logic [W:0]     q_im_i,
	output      logic           vld_o,
	input  wire logic           rdy_i,
	output      ctl_t           ctl_o,
	output      logic [W-1:0]   res_re_o,
	output      logic [W-1:0]   res_im_o,
	output      logic [2*W-1:0] den_o,
	output      logic [RW-1:0]  rem_re_o,
	output      logic [RW-1:0]  rem_im_o,
	output      logic [W:0]     q_re_o,
	output      logic [W:0]     q_im_o
);

	logic [RW-1:0] dsh;
	logic          ge_re, ge_im;
	logic [W:0]    qn_re, qn_im;

	assign rdy_o = !vld_o || rdy_i;
	assign dsh   = {{(RW-2*W){1'b0}}, den_i} << BIT;
	assign ge_re = (rem_re_i >= dsh);
	assign ge_im = (rem_im_i >= dsh);

	always_comb begin
		qn_re      = q_re_i;
		qn_im      = q_im_i;
		qn_re[BIT] = ge_re;
		qn_im[BIT] = ge_im;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (rdy_o) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o && vld_i) begin
			ctl_o    <= ctl_i;
			res_re_o <= res_re_i;
			res_im_o <= res_im_i;
			den_o    <= den_i;
			rem_re_o <= ge_re ? rem_re_i - dsh : rem_re_i;
			rem_im_o <= ge_im ? rem_im_i - dsh : rem_im_i;
			q_re_o   <= qn_re;
			q_im_o   <= qn_im;
		end
	end

endmodule

`default_nettype wire

>>> sv/cau_back.sv
// Back end of the complex arithmetic unit: signs and saturates the quotients,
// picks the final result and holds it in the output register. Depends on cau_pkg.
`default_nettype none

module cau_back import cau_pkg::*; #(
	parameter int W = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         vld_i,
	output      logic         rdy_o,
	input  wire ctl_t         ctl_i,
	input  wire logic [W-1:0] res_re_i,
	input  wire logic [W-1:0] res_im_i,
	input  wire logic [W:0]   q_re_i,
	input  wire logic [W:0]   q_im_i,
	output      logic         out_valid,
	input  wire logic         out_stall,
	output      logic [W-1:0] result_re,
	output      logic [W-1:0] result_im,
	output      logic [1:0]   status
);

	localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

	logic         ovf_re, ovf_im;
	logic [W-1:0] d_re, d_im;
	logic [W-1:0] f_re, f_im;
	logic [1:0]   f_st;

	always_comb begin
		if (ctl_i.neg_re) begin
			ovf_re = ctl_i.big_re || q_re_i[W] || (q_re_i[W-1] && (|q_re_i[W-2:0]));
			d_re   = ovf_re ? SMIN : -q_re_i[W-1:0];
		end else begin
			ovf_re = ctl_i.big_re || (|q_re_i[W:W-1]);
			d_re   = ovf_re ? SMAX : q_re_i[W-1:0];
		end
		if (ctl_i.neg_im) begin
			ovf_im = ctl_i.big_im || q_im_i[W] || (q_im_i[W-1] && (|q_im_i[W-2:0]));
			d_im   = ovf_im ? SMIN : -q_im_i[W-1:0];
		end else begin
			ovf_im = ctl_i.big_im || (|q_im_i[W:W-1]);
			d_im   = ovf_im ? SMAX : q_im_i[W-1:0];
		end
		if (ctl_i.mode != MODE_DIV) begin
			f_re = res_re_i;
			f_im = res_im_i;
			f_st = ctl_i.st;
		end else if (ctl_i.zero) begin
			f_re = '0;
			f_im = '0;
			f_st = ST_DIV0;
		end else begin
			f_re = d_re;
			f_im = d_im;
			f_st = (ovf_re || ovf_im) ? ST_OVF : ST_OK;
		end
	end

	assign rdy_o = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (rdy_o) begin
			out_valid <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o && vld_i) begin
			result_re <= f_re;
			result_im <= f_im;
			status    <= f_st;
		end
	end

endmodule

`default_nettype wire

>>> sv/complex_arithmetic_unit_top.sv
// Complex arithmetic unit: add, subtract, multiply or divide two signed fixed-point
// complex numbers. The pipeline has five front-end stages, one restoring division stage
// per quotient bit, and the output register. Throughput is one request per cycle in
// every mode unless the output stalls; a stall only holds stages that are full, so
// bubbles close up. Reset clears every valid bit asynchronously.
`default_nettype none

module complex_arithmetic_unit_top import cau_pkg::*; #(
	parameter int WIDTH     = 32,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output      logic                    in_stall,
	input  wire logic [1:0]              mode,
	input  wire logic signed [WIDTH-1:0] a_re,
	input  wire logic signed [WIDTH-1:0] a_im,
	input  wire logic signed [WIDTH-1:0] b_re,
	input  wire logic signed [WIDTH-1:0] b_im,
	output      logic                    out_valid,
	input  wire logic                    out_stall,
	output      logic signed [WIDTH-1:0] result_re,
	output      logic signed [WIDTH-1:0] result_im,
	output      logic [1:0]              status
);

	// The remainder must hold the scaled dividend and the divisor shifted by the
	// top quotient bit, whichever is wider.
	localparam int RW = 3 * WIDTH + FRAC_BITS + 2;
	localparam int NS = WIDTH + 2;

	// Element k of each array is what the k-th division stage receives; the last
	// element feeds the back end. rdy[k] is the readiness of that receiver.
	logic                 vld [NS];
	logic                 rdy [NS];
	ctl_t                 ctl [NS];
	logic [WIDTH-1:0]     res_re [NS];
	logic [WIDTH-1:0]     res_im [NS];
	logic [2*WIDTH-1:0]   den [NS];
	logic [RW-1:0]        rem_re [NS];
	logic [RW-1:0]        rem_im [NS];
	logic [WIDTH:0]       q_re [NS];
	logic [WIDTH:0]       q_im [NS];

	// Products, sums, magnitudes and the check for quotients too large to fit.
	cau_front #(.W(WIDTH), .F(FRAC_BITS), .RW(RW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.a_re     (a_re),
		.a_im     (a_im),
		.b_re     (b_re),
		.b_im     (b_im),
		.vld_o    (vld[0]),
		.rdy_i    (rdy[0]),
		.ctl_o    (ctl[0]),
		.res_re_o (res_re[0]),
		.res_im_o (res_im[0]),
		.den_o    (den[0]),
		.num_re_o (rem_re[0]),
		.num_im_o (rem_im[0])
	);

	assign q_re[0] = '0;
	assign q_im[0] = '0;

	// The quotient is built most significant bit first, one bit per stage.
	for (genvar k = 0; k <= WIDTH; k++) begin : g_div
		cau_div_step #(.W(WIDTH), .RW(RW), .BIT(WIDTH - k)) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.vld_i    (vld[k]),
			.rdy_o    (rdy[k]),
			.ctl_i    (ctl[k]),
			.res_re_i (res_re[k]),
			.res_im_i (res_im[k]),
			.den_i    (den[k]),
			.rem_re_i (rem_re[k]),
			.rem_im_i (rem_im[k]),
			.q_re_i   (q_re[k]),
			.q_im_i   (q_im[k]),
			.vld_o    (vld[k+1]),
			.rdy_i    (rdy[k+1]),
			.ctl_o    (ctl[k+1]),
			.res_re_o (res_re[k+1]),
			.res_im_o (res_im[k+1]),
			.den_o    (den[k+1]),
			.rem_re_o (rem_re[k+1]),
			.rem_im_o (rem_im[k+1]),
			.q_re_o   (q_re[k+1]),
			.q_im_o   (q_im[k+1])
		);
	end

	// Sign and saturation of the quotient, then the output register.
	cau_back #(.W(WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld_i     (vld[NS-1]),
		.rdy_o     (rdy[NS-1]),
		.ctl_i     (ctl[NS-1]),
		.res_re_i  (res_re[NS-1]),
		.res_im_i  (res_im[NS-1]),
		.q_re_i    (q_re[NS-1]),
		.q_im_i    (q_im[NS-1]),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result_re (result_re),
		.result_im (result_im),
		.status    (status)
	);

endmodule

`default_nettype wire

>>> sv/cau_checker.sv
// Port-level checks for the complex arithmetic unit, attached to the top level
// by the bind at the end of this file. Depends on cau_pkg.
`default_nettype none

module cau_checker import cau_pkg::*; #(
	parameter int WIDTH = 32
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_stall,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire logic [WIDTH-1:0] result_re,
	input wire logic [WIDTH-1:0] result_im,
	input wire logic [1:0]       status
);

	// A result that is not taken stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_re) &&
			$stable(result_im) && $stable(status))
		else $error("stalled result changed");

	// With the output register empty every stage can move, so requests are taken.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("request refused while output empty");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_OVF || status == ST_DIV0))
		else $error("unused status code");

	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DIV0 |-> result_re == '0 && result_im == '0)
		else $error("divide by zero with nonzero result");

endmodule

bind complex_arithmetic_unit_top cau_checker #(.WIDTH(WIDTH)) u_cau_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.result_re (result_re),
	.result_im (result_im),
	.status    (status)
);

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the complex arithmetic unit: random and directed requests
// are driven through the valid/stall channels and every result is compared with a
// built-in predictor. Depends on cau_pkg and complex_arithmetic_unit_top.
`default_nettype none

module testbench;
	import cau_pkg::*;

	localparam int WIDTH     = 32;
	localparam int FRAC_BITS = 16;
	localparam int LATENCY   = WIDTH + 7;
	localparam int N_RANDOM  = 1512;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] a_re;
		logic [31:0] a_im;
		logic [31:0] b_re;
		logic [31:0] b_im;
	} request_t;

	typedef struct packed {
		logic [31:0] re;
		logic [31:0] im;
		logic [1:0]  st;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  mode = MODE_ADD;
	logic [31:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] result_re, result_im;
	logic [1:0]  status;

	request_t pending_reqs[$];
	answer_t  expected_answers[$];
	int       mismatches = 0;
	longint   cycles = 0;
	bit       quiet_phase = 1'b0;
	bit       long_hold = 1'b0;
	bit       sender_pause = 1'b0;
	int       in_gap = 0;
	int       out_gap = 0;

	complex_arithmetic_unit_top #(.WIDTH(WIDTH), .FRAC_BITS(FRAC_BITS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_re(result_re), .result_im(result_im), .status(status)
	);

	always #6 clk = ~clk;

	// Clamp a wide signed value into the 32-bit range, flagging overflow.
	function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout bit ovf);
		if (v > 128'sd2147483647) begin
			ovf = 1'b1;
			return 32'h7fff_ffff;
		end
		if (v < -128'sd2147483648) begin
			ovf = 1'b1;
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	// Quotient of num * 2^FRAC_BITS by den, rounded toward zero. The magnitude is
	// capped so that huge quotients still saturate as the hardware does.
	function automatic logic signed [127:0] scaled_quotient(input logic signed [127:0] num,
			input logic signed [127:0] den);
		logic [127:0] mag;
		logic [127:0] q;
		mag = num < 0 ? -num : num;
		q = (mag << FRAC_BITS) / den;
		if (q > (128'd1 << 40)) q = 128'd1 << 40;
		return num < 0 ? -$signed(q) : $signed(q);
	endfunction

	function automatic answer_t complex_result(input request_t r);
		logic signed [127:0] ar, ai, br, bi, x, y, den;
		answer_t ans;
		bit ovf;
		ar = $signed(r.a_re); ai = $signed(r.a_im);
		br = $signed(r.b_re); bi = $signed(r.b_im);
		ovf = 1'b0;
		case (r.mode)
			MODE_ADD: begin
				x = ar + br; y = ai + bi;
			end
			MODE_SUB: begin
				x = ar - br; y = ai - bi;
			end
			MODE_MUL: begin
				// Arithmetic shift of a signed value floors, as required.
				x = (ar * br - ai * bi) >>> FRAC_BITS;
				y = (ar * bi + br * ai) >>> FRAC_BITS;
			end
			default: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					ans.re = '0; ans.im = '0; ans.st = ST_DIV0;
					return ans;
				end
				x = scaled_quotient(ar * br + ai * bi, den);
				y = scaled_quotient(ai * br - ar * bi, den);
			end
		endcase
		ans.re = clamp32(x, ovf);
		ans.im = clamp32(y, ovf);
		ans.st = ovf ? ST_OVF : ST_OK;
		return ans;
	endfunction

	// Operand values biased toward extremes, small numbers and plain random bits.
	function automatic logic [31:0] pick_part();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return '0;
			3: return $urandom_range(0, 8) << 16;
			4: return -($urandom_range(0, 8) << 16);
			5, 6: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic request_t make_request(input logic [1:0] op, input logic [31:0] ar,
			input logic [31:0] ai, input logic [31:0] br, input logic [31:0] bi);
		request_t r;
		r.mode = op; r.a_re = ar; r.a_im = ai; r.b_re = br; r.b_im = bi;
		return r;
	endfunction

	// Sender: takes the next request from the queue whenever the channel is free,
	// with bursts of idle cycles except in the quiet final phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_answers.push_back(complex_result({mode, a_re, a_im, b_re, b_im}));
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (!sender_pause && pending_reqs.size() > 0) begin
					request_t r;
					r = pending_reqs.pop_front();
					in_valid <= 1'b1;
					{mode, a_re, a_im, b_re, b_im} <= r;
					if (!quiet_phase && $urandom_range(0, 7) == 0)
						in_gap <= $urandom_range(1, 4);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stalls in short random bursts, or for a long stretch when asked to, so
	// that the pipeline fills and pushes back on the sender.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (long_hold) begin
			out_stall <= 1'b1;
		end else if (out_gap > 0) begin
			out_gap <= out_gap - 1;
			out_stall <= 1'b1;
		end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
			out_gap <= $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor: every accepted result is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result re=%h im=%h st=%0d",
						result_re, result_im, status);
			end else begin
				answer_t want;
				want = expected_answers.pop_front();
				if (want.re !== result_re || want.im !== result_im || want.st !== status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected re=%h im=%h st=%0d, got re=%h im=%h st=%0d",
							want.re, want.im, want.st, result_re, result_im, status);
				end
			end
		end
	end

	// Watchdog on total cycles.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [31:0] ext[4];
		ext[0] = 32'h7fff_ffff; ext[1] = 32'h8000_0000; ext[2] = '0; ext[3] = 32'h0001_0000;
		// Directed part: extremes in every mode, zero divisor and overflow cases.
		for (int op = 0; op < 4; op++) begin
			pending_reqs.push_back(make_request(2'(op), ext[0], ext[1], ext[0], ext[1]));
			pending_reqs.push_back(make_request(2'(op), ext[1], ext[0], ext[1], ext[0]));
			pending_reqs.push_back(make_request(2'(op), ext[3], ext[2], ext[3], ext[3]));
			pending_reqs.push_back(make_request(2'(op), 32'hffff_ffff, 32'h0002_8000,
				32'h0000_8000, 32'hfffe_0000));
		end
		pending_reqs.push_back(make_request(MODE_DIV, ext[3], ext[3], '0, '0));
		pending_reqs.push_back(make_request(MODE_DIV, ext[0], ext[1], 32'd1, '0));
		pending_reqs.push_back(make_request(MODE_DIV, ext[1], ext[1], ext[1], ext[1]));
		pending_reqs.push_back(make_request(MODE_MUL, ext[1], ext[1], ext[1], ext[1]));
		pending_reqs.push_back(make_request(MODE_DIV, 32'hffff_ffff, '0, 32'h0003_0000, '0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_RANDOM; i++) begin
			pending_reqs.push_back(make_request(2'($urandom_range(0, 3)), pick_part(),
				pick_part(), pick_part(), pick_part()));
			if (i == 300) begin
				// Long receiver hold while the sender keeps offering requests.
				while (pending_reqs.size() > 0) @(posedge clk);
				long_hold = 1'b1;
				for (int c = 0; c < 3 * LATENCY; c++) begin
					pending_reqs.push_back(make_request(2'($urandom_range(0, 3)),
						pick_part(), pick_part(), pick_part(), pick_part()));
					@(posedge clk);
				end
				long_hold = 1'b0;
			end
			if (i == 700) begin
				// Sender pause until the pipeline has drained completely.
				while (pending_reqs.size() > 0) @(posedge clk);
				sender_pause = 1'b1;
				while (in_valid || expected_answers.size() > 0) @(posedge clk);
				sender_pause = 1'b0;
			end
			if (i == N_RANDOM - 200) quiet_phase = 1'b1;
			if (pending_reqs.size() > 64) @(posedge clk);
		end

		while (pending_reqs.size() > 0 || in_valid) @(posedge clk);
		while (expected_answers.size() > 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0 && expected_answers.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
